>>> src/hsc_pkg.sv
// Shared types, codes and helpers for the hitting set critical/uncovered engine.
// No dependencies.
package hsc_pkg;

  localparam int HSC_MAX_VERTICES = 32;
  localparam int HSC_MAX_EDGES    = 64;
  localparam int HSC_SLOTS_MAX    = 32;
  localparam int HSC_FRAMES       = 32;
  localparam int HSC_FRAME_W      = 5;
  localparam int HSC_LEVEL_W      = 6;
  localparam int HSC_MASK_W       = 64;
  localparam int HSC_SET_W        = 32;
  localparam int HSC_VTX_W        = 5;
  localparam int HSC_CNT_W        = 7;

  typedef logic [HSC_MASK_W-1:0] mask_t;

  typedef enum logic [1:0] {
    REQ_TEST   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_VIOL  = 2'd1;
  localparam logic [1:0] ST_STACK = 2'd2;

  // Control word broadcast from the sequencer to every cell
  typedef struct packed {
    logic                 shift;
    logic                 clear;
    logic                 commit;
    logic [HSC_VTX_W-1:0] vertex;
    logic [HSC_SET_W-1:0] member;
    mask_t                edges;
    mask_t                vval;
  } cell_ctl_t;

  // Low min(count, max_edges) bits set
  function automatic mask_t edge_mask(logic [HSC_CNT_W-1:0] count, int max_edges);
    int n;
    n = (int'(count) > max_edges) ? max_edges : int'(count);
    if (n >= HSC_MASK_W) return '1;
    return (mask_t'(1) << n) - mask_t'(1);
  endfunction

endpackage

>>> src/hsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/hsc_cell.sv
// One ring cell: holds the critical-edge mask of one vertex.
// Depends on hsc_pkg.
module hsc_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hsc_pkg::cell_ctl_t ctl,
  input  hsc_pkg::mask_t    d_in,
  output hsc_pkg::mask_t    q
);
  import hsc_pkg::*;

  mask_t q_r, q_nxt;

  // clear, end-of-add commit, or pass to neighbor during a walk
  always_comb begin
    q_nxt = q_r;
    if (ctl.clear) begin
      q_nxt = '0;
    end else if (ctl.commit) begin
      if (ctl.vertex == HSC_VTX_W'(IDX)) begin
        q_nxt = ctl.vval;
      end else if (ctl.member[IDX]) begin
        q_nxt = q_r & ~ctl.edges;
      end
    end else if (ctl.shift) begin
      q_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

>>> src/hitting_set_crit_uncov_engine_core.sv
// Top level: sequencer, ring of critical-mask cells, mark stack RAM.
// Depends on hsc_pkg, hsc_cell, hsc_ram.
//
//  channel | direction | handshake        | word
//  in_     | input     | in_valid/in_stall | req_type, vertex, vertex_edges, member_set
//  out_    | output    | out_valid/out_stall | status, uncovered_edges, vertex_critical
//  cfg_    | input     | cfg_valid/cfg_ready | edge_count
//
// Test and add walk the ring in the run state; remove first passes a prefetch state: the ring of
// cells rotates once past the head, one mask a cycle; the prefetch state issues the first
// mark-stack read. Clear and out-of-range vertices go straight to the final state.
// One request is in flight at a time; a finished word may wait in the output register.
// Reset is synchronous: masks zero, stack empty, edge_count 64, uncovered all set.
// A stalled output holds the sequencer in its final state until the word is taken.
module hitting_set_crit_uncov_engine_core #(
  parameter int MAX_VERTICES = hsc_pkg::HSC_MAX_VERTICES,
  parameter int MAX_EDGES    = hsc_pkg::HSC_MAX_EDGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [hsc_pkg::HSC_VTX_W-1:0] in_vertex,
  input  hsc_pkg::mask_t                in_vertex_edges,
  input  logic [hsc_pkg::HSC_SET_W-1:0] in_member_set,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output hsc_pkg::mask_t                out_uncovered_edges,
  output hsc_pkg::mask_t                out_vertex_critical,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hsc_pkg::HSC_CNT_W-1:0] cfg_edge_count
);
  import hsc_pkg::*;

  localparam int SLOTS = (MAX_VERTICES < HSC_SLOTS_MAX) ? MAX_VERTICES : HSC_SLOTS_MAX;
  localparam int SW    = $clog2(SLOTS);
  localparam int DEPTH = HSC_FRAMES << SW;
  localparam int AW    = HSC_FRAME_W + SW;

  typedef enum logic [1:0] {S_IDLE, S_PREF, S_RUN, S_FIN} state_t;

  state_t                 st_r;
  req_t                   req_r;
  logic [HSC_VTX_W-1:0]   v_r;
  mask_t                  edges_r, uncov_r, capv_r;
  logic [SLOTS-1:0]       set_r;
  logic [SW-1:0]          k_r;
  logic                   viol_r, vbig_r;
  logic [HSC_LEVEL_W-1:0] lvl_r;
  logic [HSC_CNT_W-1:0]   ecount_r;
  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  mask_t                  out_uncov_r, out_vcrit_r;

  mask_t     cell_q [SLOTS];
  cell_ctl_t ctl;
  mask_t     head, head_new, covered, rd_data, emask;
  logic      in_acc, mem_k, at_v, hit, full, empty, add_ok, rem_ok, fin_go, ram_we;
  logic [HSC_FRAME_W-1:0] rframe;
  logic [AW-1:0]          waddr, raddr;
  logic [1:0]             fin_status;
  mask_t                  fin_uncov, fin_vcrit;
  logic [SLOTS-1:0]       set_in;

  assign in_stall  = (st_r != S_IDLE);
  assign cfg_ready = (st_r == S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign emask     = edge_mask(ecount_r, MAX_EDGES);
  assign set_in    = in_member_set[SLOTS-1:0] & ~(SLOTS'(1) << in_vertex);

  // walk of the ring head
  assign head    = cell_q[0];
  assign mem_k   = set_r[k_r];
  assign at_v    = (v_r[SW-1:0] == k_r);
  assign full    = (lvl_r == HSC_LEVEL_W'(HSC_FRAMES));
  assign empty   = (lvl_r == '0);
  assign covered = (req_r == REQ_TEST) ? (edges_r & ~uncov_r) : edges_r;
  assign hit     = mem_k && ((head & ~covered) == '0);
  assign add_ok  = (req_r == REQ_ADD) && !full && !viol_r;
  assign rem_ok  = (req_r == REQ_REMOVE) && !empty;

  always_comb begin
    head_new = head;
    if (rem_ok) begin
      if (at_v) begin
        head_new = '0;
      end else if (mem_k) begin
        head_new = head | rd_data;
      end
    end
  end

  // mark stack addressing: push writes frame lvl, pop reads frame lvl-1
  assign rframe = HSC_FRAME_W'(lvl_r - HSC_LEVEL_W'(1));
  assign waddr  = {lvl_r[HSC_FRAME_W-1:0], k_r};
  assign raddr  = (st_r == S_PREF) ? {rframe, SW'(0)} : {rframe, SW'(k_r + SW'(1))};
  assign ram_we = (st_r == S_RUN) && (req_r == REQ_ADD) && !full;

  // result word
  assign fin_go = (st_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    fin_status = ST_OK;
    fin_uncov  = uncov_r;
    fin_vcrit  = capv_r;
    if (req_r == REQ_CLEAR) begin
      fin_uncov = emask;
      fin_vcrit = '0;
    end else if (vbig_r) begin
      fin_vcrit = '0;
    end else begin
      case (req_r)
        REQ_TEST: fin_status = viol_r ? ST_VIOL : ST_OK;
        REQ_ADD: begin
          if (full) begin
            fin_status = ST_STACK;
          end else if (viol_r) begin
            fin_status = ST_VIOL;
            fin_vcrit  = '0;
          end else begin
            fin_uncov = uncov_r & ~edges_r;
            fin_vcrit = edges_r & uncov_r;
          end
        end
        default: begin
          if (empty) begin
            fin_status = ST_STACK;
          end else begin
            fin_vcrit = '0;
          end
        end
      endcase
    end
  end

  // sequencer, state registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      lvl_r       <= '0;
      ecount_r    <= HSC_CNT_W'(HSC_MASK_W);
      uncov_r     <= edge_mask(HSC_CNT_W'(HSC_MASK_W), MAX_EDGES);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ecount_r <= cfg_edge_count;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            req_r   <= req_t'(in_req_type);
            v_r     <= in_vertex;
            edges_r <= in_vertex_edges & emask;
            set_r   <= set_in;
            vbig_r  <= ({1'b0, in_vertex} >= (HSC_VTX_W+1)'(SLOTS));
            k_r     <= '0;
            viol_r  <= 1'b0;
            capv_r  <= '0;
            if (req_t'(in_req_type) == REQ_CLEAR ||
                {1'b0, in_vertex} >= (HSC_VTX_W+1)'(SLOTS)) begin
              st_r <= S_FIN;
            end else if (req_t'(in_req_type) == REQ_REMOVE) begin
              st_r <= S_PREF;
            end else begin
              st_r <= S_RUN;
            end
          end
        end
        S_PREF: st_r <= S_RUN;
        S_RUN: begin
          if (hit) begin
            viol_r <= 1'b1;
          end
          if (at_v) begin
            capv_r <= head;
            if (rem_ok) begin
              uncov_r <= uncov_r | head;
            end
          end
          k_r <= k_r + SW'(1);
          if (k_r == SW'(SLOTS-1)) begin
            st_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            out_status_r <= fin_status;
            out_uncov_r  <= fin_uncov;
            out_vcrit_r  <= fin_vcrit;
            uncov_r      <= fin_uncov;
            if (req_r == REQ_CLEAR) begin
              lvl_r <= '0;
            end else if (!vbig_r && add_ok) begin
              lvl_r <= lvl_r + HSC_LEVEL_W'(1);
            end else if (!vbig_r && rem_ok) begin
              lvl_r <= lvl_r - HSC_LEVEL_W'(1);
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // control broadcast to the cells
  always_comb begin
    ctl.shift  = (st_r == S_RUN);
    ctl.clear  = fin_go && (req_r == REQ_CLEAR);
    ctl.commit = fin_go && !vbig_r && (req_r == REQ_ADD) && !full;
    ctl.vertex = v_r;
    ctl.member = (add_ok) ? HSC_SET_W'(set_r) : '0;
    ctl.edges  = edges_r;
    ctl.vval   = add_ok ? (edges_r & uncov_r) : '0;
  end

  // ring of cells: each hands its mask toward cell 0, the head feeds the tail
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    hsc_cell #(.IDX(i)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .d_in ((i == SLOTS-1) ? head_new : cell_q[(i+1) % SLOTS]),
      .q    (cell_q[i])
    );
  end

  hsc_ram #(.WIDTH(HSC_MASK_W), .DEPTH(DEPTH)) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(mem_k ? (head & edges_r) : '0),
    .raddr(raddr),
    .rdata(rd_data)
  );

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_uncovered_edges = out_uncov_r;
  assign out_vertex_critical = out_vcrit_r;

  // stack level never passes the frame count
  a_lvl_max: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= HSC_LEVEL_W'(HSC_FRAMES)) else $error("stack level overflow");

  // a result word only appears after the final state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_FIN)) else $error("result without request");

  // mark stack is written only while walking an add
  a_we_add: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (st_r == S_RUN && req_r == REQ_ADD)) else $error("stray stack write");

  // successful pop lowers the level by one
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && rem_ok && !vbig_r) |=> (lvl_r == $past(lvl_r) - HSC_LEVEL_W'(1)))
    else $error("pop level mismatch");

endmodule
